// ===== rtl/core/yuyv2rgb_pkg.sv =====
`default_nettype none

package yuyv2rgb_pkg;

    // field and register widths
    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 24;

    // fixed-point widths of the color math
    localparam int LUMA_W      = 18;
    localparam int CHROMA_W    = 18;
    localparam int SUM_W       = 20;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // BT.601 integer coefficients
    localparam int COEF_Y      = 298;
    localparam int COEF_RV     = 409;
    localparam int COEF_GU     = 100;
    localparam int COEF_GV     = 208;
    localparam int COEF_BU     = 516;
    localparam int ROUND_HALF  = 128;
    localparam int LUMA_OFFSET = 16;
    localparam int CHROMA_MID  = 128;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // reset values
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    typedef enum logic [1:0] {
        MODE_YUYV  = 2'd0,
        MODE_RGB24 = 2'd1,
        MODE_BGR24 = 2'd2,
        MODE_OFF   = 2'd3
    } pixel_mode_t;

    // one queued input beat; rgb modes carry red, green, blue in a, b, c
    typedef struct packed {
        logic                       is_yuv;
        logic [BYTE_W-1:0]          a;
        logic [BYTE_W-1:0]          b;
        logic [BYTE_W-1:0]          c;
        logic signed [CHROMA_W-1:0] cr;
        logic signed [CHROMA_W-1:0] cg;
        logic signed [CHROMA_W-1:0] cb;
    } entry_t;

    // floor by 256 and clamp to 0..255
    function automatic logic [BYTE_W-1:0] clip_sum(input logic signed [SUM_W-1:0] s);
        logic [BYTE_W-1:0] res;
        if (s < 0)
        begin
            res = '0;
        end
        else if (s[SUM_W-2:2*BYTE_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = s[2*BYTE_W-1:BYTE_W];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/yuyv2rgb_front.sv =====
`default_nettype none

module yuyv2rgb_front (
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]     byte_a,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]     byte_b,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]     byte_c,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]     byte_d,
    input  wire yuyv2rgb_pkg::pixel_mode_t           mode,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output yuyv2rgb_pkg::entry_t                     q_entry
);

    logic signed [yuyv2rgb_pkg::BYTE_W:0] du;
    logic signed [yuyv2rgb_pkg::BYTE_W:0] ev;

    // take a beat whenever the queue has room
    assign in_ready = !q_full;

    // unused mode drops the beat without a queue entry
    assign q_push = in_valid && !q_full && (mode != yuyv2rgb_pkg::MODE_OFF);

    // centered chroma
    always_comb
    begin
        du = $signed({1'b0, byte_b}) - (yuyv2rgb_pkg::BYTE_W+1)'(yuyv2rgb_pkg::CHROMA_MID);
        ev = $signed({1'b0, byte_d}) - (yuyv2rgb_pkg::BYTE_W+1)'(yuyv2rgb_pkg::CHROMA_MID);
    end

    // classify the beat and precompute chroma terms with rounding
    always_comb
    begin
        q_entry.is_yuv = (mode == yuyv2rgb_pkg::MODE_YUYV);
        q_entry.a      = byte_a;
        q_entry.b      = byte_b;
        q_entry.c      = byte_c;
        if (mode == yuyv2rgb_pkg::MODE_BGR24)
        begin
            q_entry.a = byte_c;
            q_entry.c = byte_a;
        end
        q_entry.cr = yuyv2rgb_pkg::CHROMA_W'(yuyv2rgb_pkg::COEF_RV * int'(ev)
                     + yuyv2rgb_pkg::ROUND_HALF);
        q_entry.cg = yuyv2rgb_pkg::CHROMA_W'(yuyv2rgb_pkg::ROUND_HALF
                     - yuyv2rgb_pkg::COEF_GU * int'(du)
                     - yuyv2rgb_pkg::COEF_GV * int'(ev));
        q_entry.cb = yuyv2rgb_pkg::CHROMA_W'(yuyv2rgb_pkg::COEF_BU * int'(du)
                     + yuyv2rgb_pkg::ROUND_HALF);
    end

endmodule

`default_nettype wire

// ===== rtl/core/yuyv2rgb_queue.sv =====
`default_nettype none

module yuyv2rgb_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire yuyv2rgb_pkg::entry_t  push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output yuyv2rgb_pkg::entry_t       head
);

    localparam int DEPTH = yuyv2rgb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    yuyv2rgb_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/yuyv2rgb_back.sv =====
`default_nettype none

module yuyv2rgb_back #(
    parameter int TOTAL_W = 26
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               head_valid,
    input  wire yuyv2rgb_pkg::entry_t               head,
    output logic                                    pop,
    input  wire logic [TOTAL_W-1:0]                 total_m1,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]         red,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]         green,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]         blue,
    output logic                                    item_last,
    output logic                                    frame_end
);

    localparam int BW    = yuyv2rgb_pkg::BYTE_W;
    localparam int SW    = yuyv2rgb_pkg::SUM_W;
    localparam int CW    = yuyv2rgb_pkg::COUNT_W;
    localparam int CMP_W = (TOTAL_W > CW) ? TOTAL_W : CW;

    // issue control
    logic          phase_reg;
    logic          phase_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          issue;
    logic          s1_ready;
    logic          out_take;

    // issue datapath
    logic [BW-1:0]                          y_sel;
    logic signed [BW:0]                     y_off;
    logic signed [yuyv2rgb_pkg::LUMA_W-1:0] luma;
    logic signed [SW-1:0]                   sum_r;
    logic signed [SW-1:0]                   sum_g;
    logic signed [SW-1:0]                   sum_b;
    logic                                   pix_last;
    logic                                   pix_end;

    // sum stage
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic signed [SW-1:0] s1_r_reg;
    logic signed [SW-1:0] s1_g_reg;
    logic signed [SW-1:0] s1_b_reg;
    logic                 s1_last_reg;
    logic                 s1_end_reg;

    // output stage
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [BW-1:0] red_reg;
    logic [BW-1:0] green_reg;
    logic [BW-1:0] blue_reg;
    logic          last_reg;
    logic          end_reg;

    // pipeline flow
    assign out_take = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || out_take;
    assign issue    = head_valid && s1_ready;
    assign pop      = issue && (!head.is_yuv || phase_reg);
    assign pix_last = !head.is_yuv || phase_reg;

    // one pixel per issue: luma from first or second sample of the group
    always_comb
    begin
        y_sel = phase_reg ? head.c : head.a;
        y_off = $signed({1'b0, y_sel}) - (BW+1)'(yuyv2rgb_pkg::LUMA_OFFSET);
        luma  = yuyv2rgb_pkg::LUMA_W'(yuyv2rgb_pkg::COEF_Y * int'(y_off));
        if (head.is_yuv)
        begin
            sum_r = SW'(int'(luma) + int'(head.cr));
            sum_g = SW'(int'(luma) + int'(head.cg));
            sum_b = SW'(int'(luma) + int'(head.cb));
        end
        else
        begin
            // pass bytes through the clamp unchanged
            sum_r = SW'({head.a, {BW{1'b0}}});
            sum_g = SW'({head.b, {BW{1'b0}}});
            sum_b = SW'({head.c, {BW{1'b0}}});
        end
    end

    // frame position
    always_comb
    begin
        pix_end    = (CMP_W'(count_reg) >= CMP_W'(total_m1));
        count_next = count_reg;
        phase_next = phase_reg;
        if (issue)
        begin
            count_next = pix_end ? '0 : count_reg + 1'b1;
            if (head.is_yuv)
            begin
                phase_next = !phase_reg;
            end
        end
    end

    assign s1_valid_next  = s1_ready ? issue : s1_valid_reg;
    assign out_valid_next = out_take ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sum stage payload
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_r_reg    <= sum_r;
            s1_g_reg    <= sum_g;
            s1_b_reg    <= sum_b;
            s1_last_reg <= pix_last;
            s1_end_reg  <= pix_end;
        end
    end

    // clamp into the output register
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            red_reg   <= yuyv2rgb_pkg::clip_sum(s1_r_reg);
            green_reg <= yuyv2rgb_pkg::clip_sum(s1_g_reg);
            blue_reg  <= yuyv2rgb_pkg::clip_sum(s1_b_reg);
            last_reg  <= s1_last_reg;
            end_reg   <= s1_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign item_last = last_reg;
    assign frame_end = end_reg;

endmodule

`default_nettype wire

// ===== rtl/core/yuyv_to_rgb_converter_unit.sv =====
`default_nettype none

// Camera pixel stream to RGB888. pixel_mode selects YUYV 4:2:2 (each input beat
// Y0 U Y1 V gives two pixels through the BT.601 integer formula, rounded and
// clamped to 0..255), RGB24 pass-through or BGR24 red/blue swap; mode 3 swallows
// input beats with no output. The front takes a beat into a two-entry queue
// whenever the queue has room, even while the output register holds a pixel;
// the back issues one pixel per cycle unless out_ready stalls it, so RGB modes
// sustain one beat per cycle, and YUYV beats are limited by the single pixel issue
// slot of the back. A pixel passes the queue, sum stage and output register; the
// second pixel of a YUYV group issues from the same entry after the first.
// frame_end marks the last pixel of a frame of frame_width * frame_height pixels
// (0 counts as 1, sides clamp to MAX_FRAME_SIDE); the pixel counter then wraps.
// Registers must be written only while the block is idle; it does not enforce this.
module yuyv_to_rgb_converter_unit #(
    parameter int MAX_FRAME_SIDE = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [yuyv2rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [yuyv2rgb_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]      byte_a,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]      byte_b,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]      byte_c,
    input  wire logic [yuyv2rgb_pkg::BYTE_W-1:0]      byte_d,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]           red,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]           green,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]           blue,
    output logic                                      item_last,
    output logic                                      frame_end
);

    localparam int CFG_W   = yuyv2rgb_pkg::CFG_W;
    localparam int SIDE_BW = $clog2(MAX_FRAME_SIDE + 1);
    localparam int SIDE_W  = (SIDE_BW < CFG_W) ? SIDE_BW : CFG_W;
    localparam int TOTAL_W = 2 * SIDE_W;

    yuyv2rgb_pkg::pixel_mode_t mode_reg;
    logic [CFG_W-1:0]          width_reg;
    logic [CFG_W-1:0]          height_reg;
    logic [SIDE_W-1:0]         w_side;
    logic [SIDE_W-1:0]         h_side;
    logic [TOTAL_W-1:0]        total_m1_reg;
    logic [TOTAL_W-1:0]        total_m1_next;

    logic                 q_full;
    logic                 q_push;
    yuyv2rgb_pkg::entry_t q_entry;
    logic                 q_pop;
    logic                 q_head_valid;
    yuyv2rgb_pkg::entry_t q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= yuyv2rgb_pkg::MODE_YUYV;
            width_reg  <= yuyv2rgb_pkg::RESET_WIDTH;
            height_reg <= yuyv2rgb_pkg::RESET_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                yuyv2rgb_pkg::REG_PIXEL_MODE:
                begin
                    mode_reg <= yuyv2rgb_pkg::pixel_mode_t'(cfg_data[1:0]);
                end
                yuyv2rgb_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_data;
                end
                yuyv2rgb_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // frame sides limited to 1..MAX_FRAME_SIDE
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_side = SIDE_W'(1);
        end
        else if (32'(width_reg) > MAX_FRAME_SIDE)
        begin
            w_side = SIDE_W'(MAX_FRAME_SIDE);
        end
        else
        begin
            w_side = SIDE_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_side = SIDE_W'(1);
        end
        else if (32'(height_reg) > MAX_FRAME_SIDE)
        begin
            h_side = SIDE_W'(MAX_FRAME_SIDE);
        end
        else
        begin
            h_side = SIDE_W'(height_reg);
        end
    end

    // index of the last pixel of a frame, refreshed every cycle
    assign total_m1_next = (TOTAL_W'(w_side) * TOTAL_W'(h_side)) - TOTAL_W'(1);

    always_ff @(posedge clk)
    begin
        total_m1_reg <= total_m1_next;
    end

    // accept and classify
    yuyv2rgb_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .byte_a   (byte_a),
        .byte_b   (byte_b),
        .byte_c   (byte_c),
        .byte_d   (byte_d),
        .mode     (mode_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decoupling queue
    yuyv2rgb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // pixel issue, color math and output register
    yuyv2rgb_back #(
        .TOTAL_W (TOTAL_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .total_m1   (total_m1_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .item_last  (item_last),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
